// ===== src/spq_pkg.sv =====
package spq_pkg;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic        op;
    logic [1:0]  priority_req;
    logic [7:0]  age;
    logic [15:0] record_tag;
  } req_t;

  typedef struct packed {
    logic        out_valid;
    logic [1:0]  out_priority;
    logic [7:0]  out_age;
    logic [15:0] out_tag;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  prio;
    logic [7:0]  age;
    logic [15:0] tag;
  } entry_t;

  typedef struct packed {
    logic   v;
    entry_t e;
  } cell_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctl_t;

endpackage

// ===== src/spq_cell.sv =====
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::cell_ctl_t ctl,
  input  spq_pkg::entry_t   ins,
  input  spq_pkg::cell_t    left,
  input  logic              left_keep,
  input  spq_pkg::cell_t    right,
  output spq_pkg::cell_t    state,
  output logic              keep
);

  spq_pkg::cell_t slot;
  spq_pkg::cell_t slot_next;

  // Hold when this record ranks at or above the incoming one.
  assign keep = slot.v && (slot.e.prio >= ins.prio);

  always_comb begin
    slot_next = slot;
    if (ctl.enq) begin
      if (!keep) begin
        if (left_keep) begin
          slot_next.v = 1'b1;
          slot_next.e = ins;
        end else begin
          slot_next = left;
        end
      end
    end else if (ctl.deq) begin
      slot_next = right;
    end
  end

  always_ff @(posedge clk) begin
    slot.e <= slot_next.e;
    if (rst) begin
      slot.v <= 1'b0;
    end else begin
      slot.v <= slot_next.v;
    end
  end

  assign state = slot;

endmodule

// ===== src/spq_rsp_buf.sv =====
module spq_rsp_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spq_pkg::rsp_t push_data,
  output logic          space,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  logic          head_v;
  spq_pkg::rsp_t head;
  logic          skid_v;
  spq_pkg::rsp_t skid;
  logic          take_head;

  assign take_head = !head_v || rsp_ready;
  assign space     = !skid_v;

  always_ff @(posedge clk) begin
    if (take_head) begin
      if (skid_v) begin
        head <= skid;
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end else if (push) begin
      skid <= push_data;
    end
    if (rst) begin
      head_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (take_head) begin
      head_v <= skid_v || push;
      skid_v <= skid_v && push;
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  assign rsp_valid = head_v;
  assign rsp       = head;

endmodule

// ===== src/stable_priority_queue.sv =====
// Stable priority queue built as a chain of record cells.
// Request channel (req_valid/req_ready/req): op selects enqueue or dequeue;
// enqueue carries priority (3 highest), age and tag. Every request yields
// exactly one response on rsp_valid/rsp_ready/rsp.
// Enqueue places the record behind every stored record of equal or higher
// priority, so equal priorities leave in arrival order. Dequeue returns the
// head record. Status flags a full queue (enqueue dropped) or an empty one
// (dequeue ignored); occupancy gives the record count after the request.
// The response is registered in the response path before it appears on rsp.
// Throughput: one request per cycle while req_ready is high; every cell
// compares its record with the incoming priority and shifts in the same
// cycle, so the chain length does not affect the rate.
// The response path has an output register plus a skid register, so one
// more request is taken while a response waits; req_ready drops only when
// both are occupied, which happens only after the receiver stalls.
// Reset (rst, synchronous): every cell empties, the count clears and any
// pending responses are discarded.
module stable_priority_queue #(
  parameter int DEPTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spq_pkg::rsp_t rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  spq_pkg::cell_t     cells [DEPTH];
  logic [DEPTH-1:0]   keeps;
  spq_pkg::cell_ctl_t ctl;
  spq_pkg::entry_t    ins;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW+4:0]   count_wide;
  logic            push;
  logic            full;
  logic            empty;
  spq_pkg::rsp_t   res;

  assign push  = req_valid && req_ready;
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  assign ins.prio = req.priority_req;
  assign ins.age  = req.age;
  assign ins.tag  = req.record_tag;

  // Issue shift commands to the whole chain; drop requests that cannot act.
  assign ctl.enq = push && (req.op == spq_pkg::OP_ENQ) && !full;
  assign ctl.deq = push && (req.op == spq_pkg::OP_DEQ) && !empty;

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_pkg::cell_t left;
      spq_pkg::cell_t right;
      logic           left_keep;
      if (i == 0) begin : g_first
        assign left      = '0;
        assign left_keep = 1'b1;
      end else begin : g_mid
        assign left      = cells[i-1];
        assign left_keep = keeps[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
        assign right = '0;
      end else begin : g_inner
        assign right = cells[i+1];
      end
      spq_cell u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .ins       (ins),
        .left      (left),
        .left_keep (left_keep),
        .right     (right),
        .state     (cells[i]),
        .keep      (keeps[i])
      );
    end
  endgenerate

  // Track the record count alongside the chain.
  always_comb begin
    count_next = count;
    if (ctl.enq) begin
      count_next = count + CW'(1);
    end else if (ctl.deq) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  assign count_wide = (CW + 5)'(count_next);

  // Form the response from the head cell and the outcome of the request.
  always_comb begin
    res              = '0;
    res.occupancy    = count_wide[4:0];
    res.status       = spq_pkg::ST_DONE;
    if (req.op == spq_pkg::OP_ENQ) begin
      if (full) begin
        res.status = spq_pkg::ST_FULL;
      end
    end else if (empty) begin
      res.status = spq_pkg::ST_EMPTY;
    end else begin
      res.out_valid    = 1'b1;
      res.out_priority = cells[0].e.prio;
      res.out_age      = cells[0].e.age;
      res.out_tag      = cells[0].e.tag;
    end
  end

  spq_rsp_buf u_rsp_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .space     (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
